// ----- design/script_source_tokenizer_defines.svh -----
// ----------------------------------------------------------------------------
// script_source_tokenizer_defines.svh
// Assertion macros used by the tokenizer queue module.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_SOURCE_TOKENIZER_DEFINES_SVH
`define SCRIPT_SOURCE_TOKENIZER_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define SST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg
// Types, token kinds, character codes and keyword tables of the tokenizer.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int LEN_W   = 12;
    localparam int LEN_MAX = (1 << LEN_W) - 1;

    // Result group queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Token kinds.
    localparam logic [3:0] K_ID      = 4'd0;
    localparam logic [3:0] K_KEY     = 4'd1;
    localparam logic [3:0] K_INT     = 4'd2;
    localparam logic [3:0] K_FLOAT   = 4'd3;
    localparam logic [3:0] K_STR     = 4'd4;
    localparam logic [3:0] K_SHARP   = 4'd5;
    localparam logic [3:0] K_COLON   = 4'd6;
    localparam logic [3:0] K_IN      = 4'd7;
    localparam logic [3:0] K_EOL     = 4'd8;
    localparam logic [3:0] K_PLUS    = 4'd9;
    localparam logic [3:0] K_MINUS   = 4'd10;
    localparam logic [3:0] K_LPAREN  = 4'd11;
    localparam logic [3:0] K_RPAREN  = 4'd12;
    localparam logic [3:0] K_EOF     = 4'd13;
    localparam logic [3:0] K_ILLEGAL = 4'd14;
    localparam logic [3:0] K_UNTERM  = 4'd15;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_US    = 8'h5F;

    // Keyword text, left aligned in nine byte slots.
    localparam logic [71:0] KW_NAMESPACE = "namespace";
    localparam logic [71:0] KW_EXTENDS   = {"extends", 16'h0000};
    localparam logic [71:0] KW_INCLUDE   = {"include", 16'h0000};

    typedef enum logic [5:0] {
        M_IDLE   = 6'b000001,
        M_IDENT  = 6'b000010,
        M_NUMBER = 6'b000100,
        M_STRING = 6'b001000,
        M_COLON  = 6'b010000,
        M_HALT   = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [3:0]       kind;
        logic [15:0]      start;
        logic [LEN_W-1:0] len;
        logic [1:0]       kwi;
        logic [7:0]       bad;
    } res_t;

    // All results caused by one source byte.
    typedef struct packed {
        logic [1:0]     n;
        res_t [2:0]     r;
    } grp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [3:0] kw_len(logic [1:0] k);
        logic [3:0] l;
        case (k)
            2'd0:    l = 4'd9;
            2'd1:    l = 4'd7;
            2'd2:    l = 4'd7;
            default: l = 4'd0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] k, logic [3:0] idx);
        logic [71:0] w;
        logic [6:0]  b;
        case (k)
            2'd0:    w = KW_NAMESPACE;
            2'd1:    w = KW_EXTENDS;
            2'd2:    w = KW_INCLUDE;
            default: w = '0;
        endcase
        if (idx > 4'd8) begin
            return 8'h00;
        end
        b = 7'd64 - {idx, 3'b000};
        return w[b +: 8];
    endfunction

endpackage

// ----- design/sst_front.sv -----
// ----------------------------------------------------------------------------
// sst_front
// Scanner state and per-byte classification; builds the result group of
// every accepted byte.
// ----------------------------------------------------------------------------
module sst_front #(
    parameter int MAX_SOURCE    = 65536,
    parameter int MAX_TOKEN_LEN = 4095
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          ch,
    input  logic                last,
    output logic                push,
    output sst_pkg::grp_t       grp
);

    localparam int POS_W = $clog2(MAX_SOURCE);
    localparam int CAP_I = (MAX_TOKEN_LEN < sst_pkg::LEN_MAX) ? MAX_TOKEN_LEN
                                                               : sst_pkg::LEN_MAX;
    localparam logic [sst_pkg::LEN_W-1:0] LEN_CAP = sst_pkg::LEN_W'(CAP_I);
    localparam logic [POS_W-1:0]          POS_TOP = POS_W'(MAX_SOURCE - 1);

    typedef struct packed {
        logic          emit;
        logic          ok;
        sst_pkg::res_t r;
    } flush_t;

    sst_pkg::mode_t               mode_reg, mode_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic [POS_W-1:0]             start_reg, start_next;
    logic [sst_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                         dec_reg, dec_next;
    logic [2:0]                   alive_reg, alive_next;

    function automatic sst_pkg::res_t mk(logic [3:0] kind, logic [POS_W-1:0] at,
                                         logic [sst_pkg::LEN_W-1:0] len,
                                         logic [1:0] kwi, logic [7:0] bad);
        sst_pkg::res_t    r;
        logic [POS_W+15:0] ext;
        ext     = {16'h0000, at};
        r.kind  = kind;
        r.start = ext[15:0];
        r.len   = len;
        r.kwi   = kwi;
        r.bad   = bad;
        return r;
    endfunction

    function automatic sst_pkg::grp_t add(sst_pkg::grp_t g, sst_pkg::res_t r);
        if (g.n < 2'd3) begin
            g.r[g.n] = r;
            g.n      = g.n + 2'd1;
        end
        return g;
    endfunction

    function automatic logic [sst_pkg::LEN_W-1:0] grow(logic [sst_pkg::LEN_W-1:0] l);
        return (l < LEN_CAP) ? l + 1'b1 : l;
    endfunction

    // Drop every keyword whose next character is not c.
    function automatic logic [2:0] track(logic [2:0] al, logic [sst_pkg::LEN_W-1:0] tl,
                                         logic [7:0] c);
        for (int k = 0; k < 3; k++) begin
            if (al[k] && (tl >= {8'h00, sst_pkg::kw_len(2'(k))} ||
                          sst_pkg::kw_char(2'(k), tl[3:0]) != c)) begin
                al[k] = 1'b0;
            end
        end
        return al;
    endfunction

    function automatic flush_t flush(sst_pkg::mode_t m, logic [POS_W-1:0] ts,
                                     logic [sst_pkg::LEN_W-1:0] tl, logic [2:0] al,
                                     logic dc);
        flush_t f;
        logic   found;
        f.emit = 1'b0;
        f.ok   = 1'b1;
        f.r    = '0;
        found  = 1'b0;
        unique case (m)
            sst_pkg::M_IDENT:
            begin
                f.emit = 1'b1;
                f.r    = mk(sst_pkg::K_ID, ts, tl, 2'd0, 8'h00);
                for (int k = 0; k < 3; k++) begin
                    if (!found && al[k] && tl == {8'h00, sst_pkg::kw_len(2'(k))}) begin
                        f.r   = mk(sst_pkg::K_KEY, ts, tl, 2'(k), 8'h00);
                        found = 1'b1;
                    end
                end
            end
            sst_pkg::M_NUMBER:
            begin
                f.emit = 1'b1;
                f.r    = mk(dc ? sst_pkg::K_FLOAT : sst_pkg::K_INT, ts, tl, 2'd0, 8'h00);
            end
            sst_pkg::M_COLON:
            begin
                f.emit = 1'b1;
                f.r    = mk(sst_pkg::K_COLON, ts, 12'd1, 2'd0, 8'h00);
            end
            sst_pkg::M_STRING:
            begin
                f.emit = 1'b1;
                f.ok   = 1'b0;
                f.r    = mk(sst_pkg::K_UNTERM, ts, tl, 2'd0, 8'h00);
            end
            default:
            begin
            end
        endcase
        return f;
    endfunction

    always_comb
    begin
        sst_pkg::mode_t            m;
        logic [POS_W-1:0]          ts;
        logic [POS_W-1:0]          pn;
        logic [sst_pkg::LEN_W-1:0] tl;
        logic                      dc;
        logic [2:0]                al;
        logic                      used;
        logic [3:0]                sk;
        logic                      single;
        flush_t                    f;
        sst_pkg::grp_t             g;

        g    = '0;
        m    = mode_reg;
        ts   = start_reg;
        tl   = len_reg;
        dc   = dec_reg;
        al   = alive_reg;
        pn   = pos_reg;
        used = 1'b0;
        sk   = sst_pkg::K_ID;

        if (m != sst_pkg::M_HALT) begin
            if (ch == sst_pkg::CH_NUL) begin
                f = flush(m, ts, tl, al, dc);
                if (f.emit) g = add(g, f.r);
                if (f.ok) g = add(g, mk(sst_pkg::K_EOF, pos_reg, 12'd0, 2'd0, 8'h00));
                m = sst_pkg::M_HALT;
            end else begin
                // Continue the token in progress.
                unique case (m)
                    sst_pkg::M_IDENT:
                    begin
                        if (sst_pkg::is_alpha(ch)) begin
                            al   = track(al, tl, ch);
                            tl   = grow(tl);
                            used = 1'b1;
                        end else begin
                            f = flush(m, ts, tl, al, dc);
                            if (f.emit) g = add(g, f.r);
                            m = sst_pkg::M_IDLE;
                        end
                    end
                    sst_pkg::M_NUMBER:
                    begin
                        if (sst_pkg::is_digit(ch)) begin
                            tl   = grow(tl);
                            used = 1'b1;
                        end else if (ch == sst_pkg::CH_DOT && !dc) begin
                            dc   = 1'b1;
                            tl   = grow(tl);
                            used = 1'b1;
                        end else begin
                            // A second dot ends the number and is dropped.
                            used = (ch == sst_pkg::CH_DOT);
                            f = flush(m, ts, tl, al, dc);
                            if (f.emit) g = add(g, f.r);
                            m = sst_pkg::M_IDLE;
                        end
                    end
                    sst_pkg::M_STRING:
                    begin
                        tl   = grow(tl);
                        used = 1'b1;
                        if (ch == sst_pkg::CH_QUOTE) begin
                            g = add(g, mk(sst_pkg::K_STR, ts, tl, 2'd0, 8'h00));
                            m = sst_pkg::M_IDLE;
                        end
                    end
                    sst_pkg::M_COLON:
                    begin
                        if (ch == sst_pkg::CH_COLON) begin
                            g    = add(g, mk(sst_pkg::K_IN, ts, 12'd2, 2'd0, 8'h00));
                            m    = sst_pkg::M_IDLE;
                            used = 1'b1;
                        end else begin
                            f = flush(m, ts, tl, al, dc);
                            if (f.emit) g = add(g, f.r);
                            m = sst_pkg::M_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // Start a new token from this byte; white space is skipped.
                if (!used) begin
                    single = 1'b1;
                    unique case (ch)
                        sst_pkg::CH_SHARP: sk = sst_pkg::K_SHARP;
                        sst_pkg::CH_SEMI:  sk = sst_pkg::K_EOL;
                        sst_pkg::CH_PLUS:  sk = sst_pkg::K_PLUS;
                        sst_pkg::CH_MINUS: sk = sst_pkg::K_MINUS;
                        sst_pkg::CH_LPAR:  sk = sst_pkg::K_LPAREN;
                        sst_pkg::CH_RPAR:  sk = sst_pkg::K_RPAREN;
                        default:           single = 1'b0;
                    endcase
                    if (ch == sst_pkg::CH_SPACE || ch == sst_pkg::CH_TAB ||
                        ch == sst_pkg::CH_LF || ch == sst_pkg::CH_CR) begin
                        m = m;
                    end else if (ch == sst_pkg::CH_QUOTE || sst_pkg::is_alpha(ch) ||
                                 sst_pkg::is_digit(ch) || ch == sst_pkg::CH_COLON) begin
                        ts = pos_reg;
                        tl = 12'd1;
                        dc = 1'b0;
                        al = 3'b111;
                        if (ch == sst_pkg::CH_QUOTE) begin
                            m = sst_pkg::M_STRING;
                        end else if (sst_pkg::is_alpha(ch)) begin
                            m  = sst_pkg::M_IDENT;
                            al = track(3'b111, 12'd0, ch);
                        end else if (sst_pkg::is_digit(ch)) begin
                            m = sst_pkg::M_NUMBER;
                        end else begin
                            m = sst_pkg::M_COLON;
                        end
                    end else if (single) begin
                        g = add(g, mk(sk, pos_reg, 12'd1, 2'd0, 8'h00));
                    end else begin
                        g = add(g, mk(sst_pkg::K_ILLEGAL, pos_reg, 12'd1, 2'd0, ch));
                        m = sst_pkg::M_HALT;
                    end
                end

                pn = (pos_reg == POS_TOP) ? '0 : pos_reg + 1'b1;

                if (last && m != sst_pkg::M_HALT) begin
                    f = flush(m, ts, tl, al, dc);
                    if (f.emit) g = add(g, f.r);
                    if (f.ok) g = add(g, mk(sst_pkg::K_EOF, pn, 12'd0, 2'd0, 8'h00));
                    m = sst_pkg::M_HALT;
                end
            end
        end

        grp = g;

        if (last) begin
            mode_next  = sst_pkg::M_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            dec_next   = 1'b0;
            alive_next = 3'b111;
        end else begin
            mode_next  = m;
            pos_next   = pn;
            start_next = ts;
            len_next   = tl;
            dec_next   = dc;
            alive_next = al;
        end
    end

    assign push = accept && (grp.n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= sst_pkg::M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            dec_reg   <= 1'b0;
            alive_reg <= 3'b111;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            dec_reg   <= dec_next;
            alive_reg <= alive_next;
        end
    end

endmodule

// ----- design/sst_queue.sv -----
// ----------------------------------------------------------------------------
// sst_queue
// Short queue of result groups between the front and the back.
// ----------------------------------------------------------------------------
`include "script_source_tokenizer_defines.svh"

module sst_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sst_pkg::grp_t     push_grp,
    input  logic              pop,
    output sst_pkg::grp_t     head,
    output sst_pkg::q_stat_t  stat
);

    sst_pkg::grp_t                 mem_reg [sst_pkg::Q_DEPTH];
    logic [sst_pkg::Q_AW-1:0]      wr_reg, wr_next;
    logic [sst_pkg::Q_AW-1:0]      rd_reg, rd_next;
    logic [sst_pkg::Q_CW-1:0]      count_reg, count_next;

    localparam logic [sst_pkg::Q_AW-1:0] PTR_TOP = sst_pkg::Q_AW'(sst_pkg::Q_DEPTH - 1);
    localparam logic [sst_pkg::Q_CW-1:0] CNT_TOP = sst_pkg::Q_CW'(sst_pkg::Q_DEPTH);

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_TOP) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_TOP) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_reg] <= push_grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    assign head       = mem_reg[rd_reg];
    assign stat.full  = (count_reg == CNT_TOP);
    assign stat.empty = (count_reg == '0);

    `SST_ASSERT(a_no_overflow, push |-> count_reg < CNT_TOP, "group pushed into full queue")
    `SST_ASSERT(a_no_underflow, pop |-> count_reg != '0, "group popped from empty queue")
    `SST_ASSERT(a_count_up, (push && !pop) |=> count_reg == $past(count_reg) + 1'b1, "count slip")
    `SST_ASSERT(a_count_range, count_reg <= CNT_TOP, "count beyond queue depth")

endmodule

// ----- design/sst_back.sv -----
// ----------------------------------------------------------------------------
// sst_back
// Takes result groups apart and presents one result at a time from an
// output register.
// ----------------------------------------------------------------------------
module sst_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sst_pkg::grp_t               head,
    input  sst_pkg::q_stat_t            stat,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [3:0]                  kind,
    output logic [15:0]                 start_pos,
    output logic [sst_pkg::LEN_W-1:0]   token_len,
    output logic [1:0]                  keyword_index,
    output logic [7:0]                  bad_char,
    output logic                        run_last
);

    logic [1:0]     idx_reg, idx_next;
    logic           valid_reg, valid_next;
    sst_pkg::res_t  res_reg;
    logic           last_reg;
    logic           load;
    logic           final_one;

    assign load      = !stat.empty && (!valid_reg || out_ready);
    assign final_one = (idx_reg == head.n - 2'd1);
    assign pop       = load && final_one;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = final_one ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            res_reg  <= head.r[idx_reg];
            last_reg <= final_one;
        end
    end

    assign out_valid     = valid_reg;
    assign kind          = res_reg.kind;
    assign start_pos     = res_reg.start;
    assign token_len     = res_reg.len;
    assign keyword_index = res_reg.kwi;
    assign bad_char      = res_reg.bad;
    assign run_last      = last_reg;

endmodule

// ----- design/script_source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// script_source_tokenizer
// Streaming tokenizer: source bytes in, tokens (kind, start, length, keyword
// index, offending byte) out.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  in       in_valid / in_ready  ch, last
//  out      out_valid/ out_ready kind, start_pos, token_len, keyword_index,
//                                bad_char, run_last
//
//  One source byte is taken per cycle while the queue is not full; the front
//  scanner updates its state in the cycle of the request and writes all
//  results of that byte as one group. The back hands out one result per cycle
//  while out_ready is high, so a byte with two or three results is serialized;
//  the four-group queue absorbs bursts ahead of the output register. in_ready
//  falls only when the queue is full; reset clears scanner state, queue
//  pointers and the output valid flag, with no clearing pass.
// ----------------------------------------------------------------------------
module script_source_tokenizer #(
    parameter int MAX_SOURCE    = 65536,
    parameter int MAX_TOKEN_LEN = 4095
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [15:0] start_pos,
    output logic [11:0] token_len,
    output logic [1:0]  keyword_index,
    output logic [7:0]  bad_char,
    output logic        run_last
);

    logic              accept;
    logic              push;
    logic              pop;
    sst_pkg::grp_t     grp;
    sst_pkg::grp_t     head;
    sst_pkg::q_stat_t  stat;

    // The front only stalls on a full queue, never on the output side.
    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    // Front: scanner state and classification of each byte.
    sst_front #(
        .MAX_SOURCE    (MAX_SOURCE),
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .ch     (ch),
        .last   (last),
        .push   (push),
        .grp    (grp)
    );

    // Queue of result groups; bytes without results are not stored.
    sst_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (grp),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    // Back: serializes each group onto the output register.
    sst_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .stat          (stat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .start_pos     (start_pos),
        .token_len     (token_len),
        .keyword_index (keyword_index),
        .bad_char      (bad_char),
        .run_last      (run_last)
    );

endmodule
